FILE: rtl/core/xxhash32_stream_assert.svh
// Assertion macros used by the checker file.
`ifndef XXHASH32_STREAM_ASSERT_SVH
`define XXHASH32_STREAM_ASSERT_SVH

// Checked only while the block is out of reset.
`define XXH32_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define XXH32_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/xxh32_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package xxh32_pkg;

    localparam logic [31:0] P1 = 32'd2654435761;
    localparam logic [31:0] P2 = 32'd2246822519;
    localparam logic [31:0] P3 = 32'd3266489917;
    localparam logic [31:0] P4 = 32'd668265263;
    localparam logic [31:0] P5 = 32'd374761393;

    // Lane start values for a zero seed.
    localparam logic [31:0] LANE0_BASE = P1 + P2;
    localparam logic [31:0] LANE3_BASE = 32'd0 - P1;

    // Datapath operations.
    localparam logic [3:0] OP_NONE = 4'd0;
    localparam logic [3:0] OP_BYTE = 4'd1;
    localparam logic [3:0] OP_ABS1 = 4'd2;
    localparam logic [3:0] OP_ABS2 = 4'd3;
    localparam logic [3:0] OP_FIN  = 4'd4;
    localparam logic [3:0] OP_FIN2 = 4'd5;
    localparam logic [3:0] OP_TW1  = 4'd6;
    localparam logic [3:0] OP_TW2  = 4'd7;
    localparam logic [3:0] OP_TB1  = 4'd8;
    localparam logic [3:0] OP_TB2  = 4'd9;
    localparam logic [3:0] OP_AV1  = 4'd10;
    localparam logic [3:0] OP_AV2  = 4'd11;
    localparam logic [3:0] OP_OUT  = 4'd12;

    typedef struct packed {
        logic [3:0] op;
        logic [1:0] idx;
        logic [1:0] bsel;
    } t_cmd;

    typedef struct packed {
        logic [3:0] fill;
        logic       out_busy;
    } t_stat;

    function automatic logic [31:0] rotl32(input logic [31:0] x, input int n);
        rotl32 = (x << n) | (x >> (32 - n));
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/xxh32_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module xxh32_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    input  wire              i_byte_present,
    input  wire              i_last,
    output logic             o_in_ready,
    input  xxh32_pkg::t_stat i_stat,
    output xxh32_pkg::t_cmd  o_cmd
);
    import xxh32_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_ABS1 = 4'd1;
    localparam logic [3:0] S_ABS2 = 4'd2;
    localparam logic [3:0] S_FIN  = 4'd3;
    localparam logic [3:0] S_FIN2 = 4'd4;
    localparam logic [3:0] S_DEC  = 4'd5;
    localparam logic [3:0] S_TW1  = 4'd6;
    localparam logic [3:0] S_TW2  = 4'd7;
    localparam logic [3:0] S_TB1  = 4'd8;
    localparam logic [3:0] S_TB2  = 4'd9;
    localparam logic [3:0] S_AV1  = 4'd10;
    localparam logic [3:0] S_AV2  = 4'd11;
    localparam logic [3:0] S_OUT  = 4'd12;

    logic [3:0] r_state, n_state;
    logic [1:0] r_idx, n_idx;
    logic [4:0] r_pos, n_pos;
    logic       r_lastp, n_lastp;

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_pos      = r_pos;
        n_lastp    = r_lastp;
        o_in_ready = 1'b0;
        o_cmd      = '{op: OP_NONE, idx: r_idx, bsel: r_pos[1:0]};
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_byte_present) begin
                        o_cmd.op = OP_BYTE;
                    end
                    if (i_byte_present && i_stat.fill == 4'd15) begin
                        n_idx   = 2'd0;
                        n_lastp = i_last;
                        n_state = S_ABS1;
                    end else if (i_last) begin
                        n_state = S_FIN;
                    end
                end
            end
            S_ABS1: begin
                o_cmd.op = OP_ABS1;
                n_state  = S_ABS2;
            end
            S_ABS2: begin
                o_cmd.op = OP_ABS2;
                n_idx    = r_idx + 2'd1;
                if (r_idx == 2'd3) begin
                    n_state = r_lastp ? S_FIN : S_IDLE;
                end else begin
                    n_state = S_ABS1;
                end
            end
            S_FIN: begin
                o_cmd.op = OP_FIN;
                n_state  = S_FIN2;
            end
            S_FIN2: begin
                o_cmd.op = OP_FIN2;
                n_pos    = 5'd0;
                n_state  = S_DEC;
            end
            S_DEC: begin
                if (r_pos + 5'd4 <= {1'b0, i_stat.fill}) begin
                    n_state = S_TW1;
                end else if (r_pos < {1'b0, i_stat.fill}) begin
                    n_state = S_TB1;
                end else begin
                    n_state = S_AV1;
                end
            end
            S_TW1: begin
                o_cmd.op  = OP_TW1;
                o_cmd.idx = r_pos[3:2];
                n_state   = S_TW2;
            end
            S_TW2: begin
                o_cmd.op = OP_TW2;
                n_pos    = r_pos + 5'd4;
                n_state  = S_DEC;
            end
            S_TB1: begin
                o_cmd.op  = OP_TB1;
                o_cmd.idx = r_pos[3:2];
                n_state   = S_TB2;
            end
            S_TB2: begin
                o_cmd.op = OP_TB2;
                n_pos    = r_pos + 5'd1;
                n_state  = S_DEC;
            end
            S_AV1: begin
                o_cmd.op = OP_AV1;
                n_state  = S_AV2;
            end
            S_AV2: begin
                o_cmd.op = OP_AV2;
                n_state  = S_OUT;
            end
            S_OUT: begin
                if (!i_stat.out_busy) begin
                    o_cmd.op = OP_OUT;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= 2'd0;
            r_pos   <= 5'd0;
            r_lastp <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_pos   <= n_pos;
            r_lastp <= n_lastp;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/xxh32_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module xxh32_dp (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  xxh32_pkg::t_cmd  i_cmd,
    output xxh32_pkg::t_stat o_stat,
    input  wire  [7:0]       i_data_byte,
    input  wire              i_cfg_valid,
    input  wire  [31:0]      i_seed,
    output logic [31:0]      o_hash,
    output logic             o_out_valid,
    input  wire              i_out_ready
);
    import xxh32_pkg::*;

    logic [31:0] r_seed;
    logic [31:0] r_lane [4];
    logic [31:0] r_word [4];
    logic [31:0] r_len;
    logic        r_large;
    logic        r_in_msg;
    logic [31:0] r_m;
    logic [31:0] r_h;
    logic [31:0] r_hash;
    logic        r_out_valid;

    logic [31:0] word_sel;
    logic [7:0]  byte_sel;
    logic [31:0] mul_a, mul_b, prod;
    logic [31:0] merge;
    logic [31:0] load_seed;
    logic        do_load;

    assign word_sel = r_word[i_cmd.idx];
    assign byte_sel = word_sel[{i_cmd.bsel, 3'b000} +: 8];
    assign merge    = (rotl32(r_lane[0], 1) + rotl32(r_lane[1], 7))
                    + (rotl32(r_lane[2], 12) + rotl32(r_lane[3], 18));

    always_comb begin
        mul_a = word_sel;
        mul_b = P2;
        unique case (i_cmd.op)
            OP_ABS1: begin mul_a = word_sel;                            mul_b = P2; end
            OP_ABS2: begin mul_a = rotl32(r_lane[i_cmd.idx] + r_m, 13); mul_b = P1; end
            OP_TW1:  begin mul_a = word_sel;                            mul_b = P3; end
            OP_TW2:  begin mul_a = rotl32(r_h + r_m, 17);               mul_b = P4; end
            OP_TB1:  begin mul_a = {24'd0, byte_sel};                   mul_b = P5; end
            OP_TB2:  begin mul_a = rotl32(r_h + r_m, 11);               mul_b = P1; end
            OP_AV1:  begin mul_a = r_h ^ (r_h >> 15);                   mul_b = P2; end
            OP_AV2:  begin mul_a = r_h ^ (r_h >> 13);                   mul_b = P3; end
            default: begin mul_a = word_sel;                            mul_b = P2; end
        endcase
    end

    assign prod = mul_a * mul_b;

    // Lanes reload at message end, or when the seed changes between messages.
    assign do_load   = (i_cmd.op == OP_OUT) || (i_cfg_valid && !r_in_msg);
    assign load_seed = i_cfg_valid ? i_seed : r_seed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed      <= 32'd0;
            r_lane[0]   <= LANE0_BASE;
            r_lane[1]   <= P2;
            r_lane[2]   <= 32'd0;
            r_lane[3]   <= LANE3_BASE;
            r_len       <= 32'd0;
            r_large     <= 1'b0;
            r_in_msg    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_seed <= i_seed;
            end
            if (do_load) begin
                r_lane[0] <= load_seed + LANE0_BASE;
                r_lane[1] <= load_seed + P2;
                r_lane[2] <= load_seed;
                r_lane[3] <= load_seed + LANE3_BASE;
            end else if (i_cmd.op == OP_ABS2) begin
                r_lane[i_cmd.idx] <= prod;
            end
            // Load a new hash, or drop the one just taken.
            if (i_cmd.op == OP_OUT) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (i_cmd.op)
                OP_BYTE: begin
                    r_len    <= r_len + 32'd1;
                    r_in_msg <= 1'b1;
                end
                OP_ABS2: begin
                    if (i_cmd.idx == 2'd3) begin
                        r_large <= 1'b1;
                    end
                end
                OP_OUT: begin
                    r_len    <= 32'd0;
                    r_large  <= 1'b0;
                    r_in_msg <= 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_BYTE) begin
            r_word[r_len[3:2]][{r_len[1:0], 3'b000} +: 8] <= i_data_byte;
        end
        unique case (i_cmd.op)
            OP_ABS1, OP_TW1, OP_TB1: r_m <= prod;
            OP_FIN:  r_h <= r_large ? merge : r_lane[2] + P5;
            OP_FIN2: r_h <= r_h + r_len;
            OP_TW2, OP_TB2, OP_AV1, OP_AV2: r_h <= prod;
            OP_OUT:  r_hash <= r_h ^ (r_h >> 16);
            default: begin
            end
        endcase
    end

    assign o_stat.fill     = r_len[3:0];
    assign o_stat.out_busy = r_out_valid && !i_out_ready;
    assign o_hash          = r_hash;
    assign o_out_valid     = r_out_valid;

endmodule

`default_nettype wire

FILE: rtl/core/xxhash32_stream.sv
// xxhash32_stream: 32-bit xxHash over a byte stream.
// Input channel (i_in_valid / o_in_ready): one transaction carries one byte
// (i_data_byte, qualified by i_byte_present) and an end mark (i_last). A
// transaction with neither a byte nor an end mark is ignored.
// Output channel (o_out_valid / i_out_ready): one transaction per message,
// o_hash, sent after the transaction that carried i_last.
// Config channel (i_cfg_valid / o_cfg_ready): writes the seed; always ready.
// A seed written mid-message takes effect on the next message.
// Throughput: a byte is taken every cycle while o_in_ready is high; input
// stalls after the byte that fills a 16-byte block, while the single shared
// 32x32 multiplier runs two passes per lane over the four lanes.
// After the end mark: the lane rounds if the end byte closed a block, then
// merge, length, each tail word and tail byte (up to 3 words and 3 bytes),
// avalanche and output; the hash appears in the cycle after the output step.
// The output register holds the hash until taken; a stalled receiver stops
// the next message only when its hash is ready to be written.
// Reset (i_rst_n low, synchronous) clears the seed, length and output valid
// and loads the lanes for a zero seed.
`timescale 1ns / 1ps
`default_nettype none

module xxhash32_stream (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    output logic        o_in_ready,
    input  wire  [7:0]  i_data_byte,
    input  wire         i_byte_present,
    input  wire         i_last,
    output logic        o_out_valid,
    input  wire         i_out_ready,
    output logic [31:0] o_hash,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [31:0] i_seed
);
    import xxh32_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // Seed writes are registered as they arrive; never stall them.
    assign o_cfg_ready = 1'b1;

    xxh32_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_byte_present (i_byte_present),
        .i_last         (i_last),
        .o_in_ready     (o_in_ready),
        .i_stat         (stat),
        .o_cmd          (cmd)
    );

    xxh32_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_data_byte (i_data_byte),
        .i_cfg_valid (i_cfg_valid),
        .i_seed      (i_seed),
        .o_hash      (o_hash),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready)
    );

endmodule

`default_nettype wire

FILE: rtl/core/xxh32_check.sv
`timescale 1ns / 1ps
`default_nettype none
`include "xxhash32_stream_assert.svh"

module xxh32_check (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_in_valid,
    input wire        o_in_ready,
    input wire [7:0]  i_data_byte,
    input wire        i_byte_present,
    input wire        i_last,
    input wire        o_out_valid,
    input wire        i_out_ready,
    input wire [31:0] o_hash,
    input wire        i_cfg_valid,
    input wire        o_cfg_ready,
    input wire [31:0] i_seed
);

    `XXH32_ASSERT_ALWAYS(a_reset_clears_out, i_clk, !i_rst_n |=> !o_out_valid, "out valid after reset")
    `XXH32_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_hash), "stalled hash changed")
    `XXH32_ASSERT(a_end_stalls_input, i_clk, i_rst_n, i_in_valid && o_in_ready && i_last |=> !o_in_ready, "input taken during finish")
    `XXH32_ASSERT(a_min_latency, i_clk, i_rst_n, i_in_valid && o_in_ready && i_last |=> ##1 !$rose(o_out_valid), "hash too early")

endmodule

bind xxhash32_stream xxh32_check u_check (.*);

`default_nettype wire
